/* sv/ltm_pkg.sv */
// ----------------------------------------------------------------------------
// ltm_pkg
// Shared constants and types for the leading-track toward-multiplicity block.
// ----------------------------------------------------------------------------
package ltm_pkg;

   localparam int MAX_TRACKS = 256;
   localparam int IDX_W      = $clog2(MAX_TRACKS);
   localparam int HELD_W     = $clog2(MAX_TRACKS + 1);
   localparam int ADDR_W     = IDX_W + 1;          // bank bit + track index
   localparam int COUNT_W    = 9;
   localparam int PT_W       = 16;
   localparam int ETA_W      = 14;
   localparam int PHI_W      = 16;
   localparam int WIN_W      = 13;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ETA_WINDOW = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PHI_LIMIT  = 8'd1;

   localparam logic [WIN_W-1:0] ETA_WINDOW_RST = 13'd2560;
   localparam logic [PHI_W-1:0] PHI_LIMIT_RST  = 16'd10923;

   // One write request into the per-track store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PHI_W-1:0]  phi;
      logic              eta_ok;
   } trk_wr_type;

   // Event summary handed from front to back
   typedef struct packed {
      logic              bank;
      logic [HELD_W-1:0] held;
      logic [PT_W-1:0]   best_pt;
      logic [PHI_W-1:0]  best_phi;
      logic              dropped;
   } evt_desc_type;

endpackage

/* sv/ltm_front.sv */
// ----------------------------------------------------------------------------
// ltm_front
// Takes tracks, flags eta acceptance, writes the track store and keeps the
// leading track; closes an event into a summary on the last track.
// ----------------------------------------------------------------------------
module ltm_front import ltm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [PT_W-1:0]    track_pt,
   input  logic [ETA_W-1:0]   track_eta,
   input  logic [PHI_W-1:0]   track_phi,
   input  logic               last_track,
   input  logic [WIN_W-1:0]   eta_window,
   output trk_wr_type         trk_wr,
   output logic               evt_push,
   output evt_desc_type       evt_desc
);

   logic [HELD_W-1:0] held_ff, held_in;
   logic [PT_W-1:0]   best_pt_ff, best_pt_in;
   logic [PHI_W-1:0]  best_phi_ff, best_phi_in;
   logic              best_valid_ff, best_valid_in;
   logic              dropped_ff, dropped_in;
   logic              bank_ff, bank_in;

   logic signed [ETA_W:0] eta_s;
   logic signed [ETA_W:0] win_s;
   logic                  eta_ok;

   assign eta_s  = {track_eta[ETA_W-1], track_eta};
   assign win_s  = $signed({2'b00, eta_window});
   assign eta_ok = (eta_s > -win_s) && (eta_s < win_s);

   always_comb begin
      held_in       = held_ff;
      best_pt_in    = best_pt_ff;
      best_phi_in   = best_phi_ff;
      best_valid_in = best_valid_ff;
      dropped_in    = dropped_ff;
      bank_in       = bank_ff;
      trk_wr        = '0;
      evt_push      = 1'b0;
      evt_desc      = '0;
      if (accept) begin
         if (held_ff < HELD_W'(MAX_TRACKS)) begin
            trk_wr.we     = 1'b1;
            trk_wr.addr   = {bank_ff, held_ff[IDX_W-1:0]};
            trk_wr.phi    = track_phi;
            trk_wr.eta_ok = eta_ok;
            held_in       = held_ff + HELD_W'(1);
            // ties keep the earlier track
            if (!best_valid_ff || (track_pt > best_pt_ff)) begin
               best_pt_in    = track_pt;
               best_phi_in   = track_phi;
               best_valid_in = 1'b1;
            end
         end else begin
            dropped_in = 1'b1;
         end
         if (last_track) begin
            evt_push          = 1'b1;
            evt_desc.bank     = bank_ff;
            evt_desc.held     = held_in;
            evt_desc.best_pt  = best_pt_in;
            evt_desc.best_phi = best_phi_in;
            evt_desc.dropped  = dropped_in;
            held_in       = '0;
            best_pt_in    = '0;
            best_phi_in   = '0;
            best_valid_in = 1'b0;
            dropped_in    = 1'b0;
            bank_in       = ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         best_pt_ff    <= '0;
         best_phi_ff   <= '0;
         best_valid_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         bank_ff       <= 1'b0;
      end else begin
         held_ff       <= held_in;
         best_pt_ff    <= best_pt_in;
         best_phi_ff   <= best_phi_in;
         best_valid_ff <= best_valid_in;
         dropped_ff    <= dropped_in;
         bank_ff       <= bank_in;
      end
   end

endmodule

/* sv/ltm_queue.sv */
// ----------------------------------------------------------------------------
// ltm_queue
// Two-entry queue of event summaries between front and back.
// ----------------------------------------------------------------------------
module ltm_queue import ltm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  evt_desc_type push_desc,
   input  logic         pop,
   output evt_desc_type head_desc,
   output logic [1:0]   q_count
);

   evt_desc_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign head_desc = slot_ff[rd_ptr_ff];
   assign q_count   = count_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/ltm_back.sv */
// ----------------------------------------------------------------------------
// ltm_back
// Holds the two-bank track store; walks an event's tracks one per cycle,
// counts those in the toward region and drives the result register.
// ----------------------------------------------------------------------------
module ltm_back import ltm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  trk_wr_type         trk_wr,
   input  logic [1:0]         q_count,
   input  evt_desc_type       head_desc,
   output logic               pop,
   output logic               busy,
   input  logic [PHI_W-1:0]   phi_limit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PT_W-1:0]    rsp_pt,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_ovf
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_type;

   logic [PHI_W:0] mem [2*MAX_TRACKS];

   state_type          state_ff, state_in;
   evt_desc_type       desc_ff, desc_in;
   logic [HELD_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [PHI_W:0]     rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0]    rsp_pt_ff, rsp_pt_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [PHI_W-1:0] diff;
   logic [PHI_W:0]   phi_dist;
   logic             near;

   // wrapped azimuth distance of the returned entry to the leading track
   assign diff     = rd_data_ff[PHI_W:1] - desc_ff.best_phi;
   assign phi_dist = (diff > 16'd32768) ? (17'd65536 - {1'b0, diff}) : {1'b0, diff};
   assign near     = rd_data_ff[0] && (phi_dist < {1'b0, phi_limit});

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pt    = rsp_pt_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_ovf   = rsp_ovf_ff;
   assign rd_addr   = {desc_ff.bank, idx_ff[IDX_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_en        = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pt_in    = rsp_pt_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rd_pend_ff && near && (cnt_ff != {COUNT_W{1'b1}})) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_count != 2'd0) begin
               pop      = 1'b1;
               desc_in  = head_desc;
               idx_in   = '0;
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (idx_ff < desc_ff.held) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               idx_in     = idx_ff + HELD_W'(1);
            end else if (!rd_pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pt_in    = desc_ff.best_pt;
               rsp_count_in = cnt_ff;
               rsp_ovf_in   = desc_ff.dropped;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (trk_wr.we) begin
         mem[trk_wr.addr] <= {trk_wr.phi, trk_wr.eta_ok};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      desc_ff      <= desc_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      rsp_pt_ff    <= rsp_pt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/leading_track_toward_multiplicity.sv */
// Throughput: one track per cycle into the store while req_tready is high; the back walk
//   reads one stored track per cycle from its memory port.
// Two events may be outstanding (two store banks); input stalls behind a third.
// Reset (synchronous, active high) clears event state, queue and result; CSRs return to defaults.
// ----------------------------------------------------------------------------
// leading_track_toward_multiplicity
// Leading-track pT and toward-region track count per event, with overflow.
// ----------------------------------------------------------------------------
module leading_track_toward_multiplicity import ltm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,  // track_pt[15:0], track_eta[29:16], track_phi[45:30]
   input  logic                  req_tlast,  // last_track
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // leading_pt[15:0], toward_count[24:16], overflow[25]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [WIN_W-1:0]   eta_window_ff;
   logic [PHI_W-1:0]   phi_limit_ff;
   trk_wr_type         trk_wr;
   logic               evt_push;
   evt_desc_type       evt_desc;
   evt_desc_type       head_desc;
   logic [1:0]         q_count;
   logic               pop;
   logic               busy;
   logic               req_accept;
   logic [PT_W-1:0]    rsp_pt;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_ovf;

   assign csr_ready  = 1'b1;
   assign req_tready = (q_count == 2'd0) || ((q_count == 2'd1) && !busy);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tdata  = {6'd0, rsp_ovf, rsp_count, rsp_pt};

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_window_ff <= ETA_WINDOW_RST;
         phi_limit_ff  <= PHI_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ETA_WINDOW: eta_window_ff <= csr_data[WIN_W-1:0];
            REG_PHI_LIMIT:  phi_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   ltm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .track_pt   (req_tdata[15:0]),
      .track_eta  (req_tdata[29:16]),
      .track_phi  (req_tdata[45:30]),
      .last_track (req_tlast),
      .eta_window (eta_window_ff),
      .trk_wr     (trk_wr),
      .evt_push   (evt_push),
      .evt_desc   (evt_desc)
   );

   ltm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_desc (evt_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_count   (q_count)
   );

   ltm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .trk_wr    (trk_wr),
      .q_count   (q_count),
      .head_desc (head_desc),
      .pop       (pop),
      .busy      (busy),
      .phi_limit (phi_limit_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_pt    (rsp_pt),
      .rsp_count (rsp_count),
      .rsp_ovf   (rsp_ovf)
   );

endmodule

/* sv/ltm_checker.sv */
// ----------------------------------------------------------------------------
// ltm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ltm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // count can never exceed the store capacity
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:16] <= 9'd256))
      else $error("toward count above capacity");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:26] == 6'd0))
      else $error("result padding not zero");

   // first edge after reset release
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && csr_ready)
      else $error("result pending right after reset");

endmodule

bind leading_track_toward_multiplicity ltm_checker u_ltm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
